/* rtl/rv32im_instruction_executor_assert.svh */
// ----------------------------------------------------------------------------
// RV32IM executor assertion macros
// Shorthand for clocked port checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RV32IM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RV32IM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define RV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("executor port check failed");

// next-cycle implication
`define RV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("executor port check failed");

`endif

/* rtl/rv32_pkg.sv */
// ----------------------------------------------------------------------------
// RV32IM executor package
// Codes, state types and controller/datapath link structs.
// ----------------------------------------------------------------------------
package rv32_pkg;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [1:0] FN_EXEC   = 2'd0;
  localparam logic [1:0] FN_LOAD   = 2'd1;
  localparam logic [1:0] FN_RESUME = 2'd2;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_ECALL   = 3'd2;
  localparam logic [2:0] ST_HALTED  = 3'd3;
  localparam logic [2:0] ST_ILLEGAL = 3'd4;

  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  typedef enum logic [1:0] {
    M_RUN   = 2'd0,
    M_LOAD  = 2'd1,
    M_ECALL = 2'd2,
    M_HALT  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage

/* rtl/rv32im_instruction_executor.sv */
// Each beat passes the register-file read, then the multiplier register for multiply or the
// 32-step divider for divide/remainder, then the result register; commit waits out_stall.
// Throughput: one beat in flight; the next is taken once the result is registered.
// The result register holds a finished beat while the next one is accepted.
// Synchronous reset clears the register file valid bits, pc to 0 and mode to running;
// a start_pc write reloads pc and mode but keeps the register file.
// ----------------------------------------------------------------------------
// RV32IM instruction executor
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module rv32im_instruction_executor import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] instruction,
  input  logic [31:0] return_data,
  input  logic        write_a0,
  input  logic        keep_running,
  input  logic        start_pc_write,
  input  logic [31:0] start_pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] cur_pc,
  output logic [31:0] next_pc,
  output logic        is_branch,
  output logic        taken,
  output logic        reg_write,
  output logic [4:0]  reg_index,
  output logic [31:0] write_value,
  output logic [31:0] access_addr,
  output logic [31:0] mem_data,
  output logic [2:0]  mem_bytes,
  output logic [31:0] call_code
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rv32_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rv32_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .instruction    (instruction),
    .return_data    (return_data),
    .write_a0       (write_a0),
    .keep_running   (keep_running),
    .start_pc_write (start_pc_write),
    .start_pc       (start_pc),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .cur_pc         (cur_pc),
    .next_pc        (next_pc),
    .is_branch      (is_branch),
    .taken          (taken),
    .reg_write      (reg_write),
    .reg_index      (reg_index),
    .write_value    (write_value),
    .access_addr    (access_addr),
    .mem_data       (mem_data),
    .mem_bytes      (mem_bytes),
    .call_code      (call_code)
  );

endmodule

/* rtl/rv32_datapath.sv */
// ----------------------------------------------------------------------------
// RV32IM executor datapath
// Register file, pc, wait mode, ALU, multiplier, divider, result register.
// ----------------------------------------------------------------------------
module rv32_datapath import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  func,
  input  logic [31:0] instruction,
  input  logic [31:0] return_data,
  input  logic        write_a0,
  input  logic        keep_running,
  input  logic        start_pc_write,
  input  logic [31:0] start_pc,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] cur_pc,
  output logic [31:0] next_pc,
  output logic        is_branch,
  output logic        taken,
  output logic        reg_write,
  output logic [4:0]  reg_index,
  output logic [31:0] write_value,
  output logic [31:0] access_addr,
  output logic [31:0] mem_data,
  output logic [2:0]  mem_bytes,
  output logic [31:0] call_code
);

  logic [31:0] rf [32];
  logic [31:0] rf_ok;
  logic [4:0]  ra_addr, rb_addr;
  logic [31:0] ra_dat, rb_dat;
  logic        ra_ok, rb_ok;
  logic [31:0] a, b;

  logic [1:0]  func_q;
  logic [31:0] ins_q, rdata_q;
  logic        wa0_q, keep_q;

  logic [31:0] pc;
  mode_t       mode;
  logic [4:0]  pend_dest;
  logic [2:0]  pend_kind;

  logic [63:0] prod;
  logic [31:0] div_rem, div_quo, div_dvs;
  logic [4:0]  div_cnt;
  logic [32:0] div_sh, div_diff;

  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs2f;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immj, immu;
  logic        run_exec;

  logic [2:0]  r_status, r_bytes, pk_next;
  logic [31:0] r_cur, r_next, r_val, r_addr, r_data, r_call, pc_next, npc;
  logic        r_br, r_tk, r_rw, wr;
  logic [4:0]  r_idx, pd_next;
  mode_t       mode_next;
  logic [31:0] hsu, qs, rs, divres;
  logic        lt_ab, ltu_ab, lt_ai, ltu_ai;

  assign ra_addr = (instruction[6:0] == OP_SYSTEM) ? REG_A0 : instruction[19:15];
  assign rb_addr = (instruction[6:0] == OP_SYSTEM) ? REG_A7 : instruction[24:20];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ra_dat  <= rf[ra_addr];
      rb_dat  <= rf[rb_addr];
      func_q  <= func;
      ins_q   <= instruction;
      rdata_q <= return_data;
      wa0_q   <= write_a0;
      keep_q  <= keep_running;
    end
    if (cmd.commit && wr && r_idx != 5'd0) begin
      rf[r_idx] <= r_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok <= '0;
      ra_ok <= 1'b0;
      rb_ok <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ra_ok <= rf_ok[ra_addr];
        rb_ok <= rf_ok[rb_addr];
      end
      if (cmd.commit && wr && r_idx != 5'd0) begin
        rf_ok[r_idx] <= 1'b1;
      end
    end
  end

  assign a = ra_ok ? ra_dat : 32'd0;
  assign b = rb_ok ? rb_dat : 32'd0;

  assign opc  = ins_q[6:0];
  assign rd   = ins_q[11:7];
  assign f3   = ins_q[14:12];
  assign rs2f = ins_q[24:20];
  assign f7   = ins_q[31:25];
  assign immi = {{20{ins_q[31]}}, ins_q[31:20]};
  assign imms = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
  assign immb = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
  assign immj = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
  assign immu = {ins_q[31:12], 12'd0};
  assign run_exec = (func_q == FN_EXEC) && (mode == M_RUN);

  assign sts.is_mul   = run_exec && opc == OP_REG && f7 == F7_MULDIV && !f3[2];
  assign sts.is_div   = run_exec && opc == OP_REG && f7 == F7_MULDIV && f3[2];
  assign sts.div_last = (div_cnt == 5'd31);
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 64'(a) * 64'(b);
    end
  end

  assign div_sh   = {div_rem, div_quo[31]};
  assign div_diff = div_sh - {1'b0, div_dvs};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= 32'd0;
      div_quo <= (!f3[0] && a[31]) ? 32'd0 - a : a;
      div_dvs <= (!f3[0] && b[31]) ? 32'd0 - b : b;
      div_cnt <= 5'd0;
    end else if (cmd.div_step) begin
      div_rem <= div_diff[32] ? div_sh[31:0] : div_diff[31:0];
      div_quo <= {div_quo[30:0], ~div_diff[32]};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  assign qs = (a[31] ^ b[31]) ? 32'd0 - div_quo : div_quo;
  assign rs = a[31] ? 32'd0 - div_rem : div_rem;
  assign hsu = prod[63:32] - (a[31] ? b : 32'd0);

  always_comb begin
    unique case (f3[1:0])
      2'd0:    divres = (b == 32'd0) ? 32'hFFFF_FFFF : qs;
      2'd1:    divres = div_quo;
      2'd2:    divres = (b == 32'd0) ? a : rs;
      default: divres = div_rem;
    endcase
  end

  assign lt_ab  = $signed(a) < $signed(b);
  assign ltu_ab = a < b;
  assign lt_ai  = $signed(a) < $signed(immi);
  assign ltu_ai = a < immi;

  always_comb begin
    r_status  = ST_DONE;
    r_cur     = pc;
    r_next    = pc;
    r_br      = 1'b0;
    r_tk      = 1'b0;
    r_rw      = 1'b0;
    r_idx     = 5'd0;
    r_val     = 32'd0;
    r_addr    = 32'd0;
    r_data    = 32'd0;
    r_bytes   = 3'd0;
    r_call    = 32'd0;
    wr        = 1'b0;
    pc_next   = pc;
    mode_next = mode;
    pd_next   = pend_dest;
    pk_next   = pend_kind;
    npc       = pc + 32'd4;
    if (run_exec) begin
      unique case (opc)
        OP_LUI: begin
          wr = 1'b1; r_val = immu;
        end
        OP_AUIPC: begin
          wr = 1'b1; r_val = pc + immu;
        end
        OP_JAL: begin
          wr = 1'b1; r_val = pc + 32'd4; npc = pc + immj;
        end
        OP_JALR: begin
          if (f3 == 3'd0) begin
            wr = 1'b1; r_val = pc + 32'd4; npc = (a + immi) & ~32'd1;
          end
        end
        OP_BRANCH: begin
          r_br = 1'b1;
          case (f3)
            3'd0:    r_tk = (a == b);
            3'd1:    r_tk = (a != b);
            3'd4:    r_tk = lt_ab;
            3'd5:    r_tk = !lt_ab;
            3'd6:    r_tk = ltu_ab;
            3'd7:    r_tk = !ltu_ab;
            default: r_tk = 1'b0;
          endcase
          if (r_tk) npc = pc + immb;
        end
        OP_IMM: begin
          wr = 1'b1;
          case (f3)
            3'd0: r_val = a + immi;
            3'd2: r_val = {31'd0, lt_ai};
            3'd3: r_val = {31'd0, ltu_ai};
            3'd4: r_val = a ^ immi;
            3'd6: r_val = a | immi;
            3'd7: r_val = a & immi;
            3'd1: begin
              if (f7 == F7_BASE) r_val = a << rs2f; else wr = 1'b0;
            end
            default: begin
              if (f7 == F7_BASE) r_val = a >> rs2f;
              else if (f7 == F7_ALT) r_val = 32'($signed(a) >>> rs2f);
              else wr = 1'b0;
            end
          endcase
        end
        OP_REG: begin
          wr = 1'b1;
          if (f7 == F7_BASE) begin
            case (f3)
              3'd0:    r_val = a + b;
              3'd1:    r_val = a << b[4:0];
              3'd2:    r_val = {31'd0, lt_ab};
              3'd3:    r_val = {31'd0, ltu_ab};
              3'd4:    r_val = a ^ b;
              3'd5:    r_val = a >> b[4:0];
              3'd6:    r_val = a | b;
              default: r_val = a & b;
            endcase
          end else if (f7 == F7_ALT) begin
            if (f3 == 3'd0) r_val = a - b;
            else if (f3 == 3'd5) r_val = 32'($signed(a) >>> b[4:0]);
            else wr = 1'b0;
          end else if (f7 == F7_MULDIV) begin
            case (f3)
              3'd0:    r_val = prod[31:0];
              3'd1:    r_val = hsu - (b[31] ? a : 32'd0);
              3'd2:    r_val = hsu;
              3'd3:    r_val = prod[63:32];
              default: r_val = divres;
            endcase
          end else begin
            wr = 1'b0;
          end
        end
        OP_STORE: begin
          if (f3 <= 3'd2) begin
            r_addr  = a + imms;
            r_bytes = 3'(3'd1 << f3);
            case (f3)
              3'd0:    r_data = {24'd0, b[7:0]};
              3'd1:    r_data = {16'd0, b[15:0]};
              default: r_data = b;
            endcase
          end
        end
        OP_LOAD: begin
          r_status  = ST_LOAD;
          r_addr    = a + immi;
          r_bytes   = (f3 == 3'd3 || f3 >= 3'd6) ? 3'd0 : 3'(3'd1 << f3[1:0]);
          r_idx     = rd;
          pd_next   = rd;
          pk_next   = f3;
          mode_next = M_LOAD;
        end
        OP_SYSTEM: begin
          if (f3 == 3'd0 && ins_q[31:20] == 12'd0) begin
            r_status  = ST_ECALL;
            r_val     = a;
            r_call    = b;
            mode_next = M_ECALL;
          end
        end
        default: begin
          r_status  = ST_ILLEGAL;
          npc       = pc;
          mode_next = M_HALT;
        end
      endcase
      if (wr) begin
        r_rw  = (rd != 5'd0);
        r_idx = rd;
      end
      r_next  = npc;
      pc_next = npc;
    end else if (func_q == FN_LOAD && mode == M_LOAD) begin
      wr = 1'b1;
      case (pend_kind)
        3'd0:    r_val = {{24{rdata_q[7]}}, rdata_q[7:0]};
        3'd1:    r_val = {{16{rdata_q[15]}}, rdata_q[15:0]};
        3'd2:    r_val = rdata_q;
        3'd4:    r_val = {24'd0, rdata_q[7:0]};
        3'd5:    r_val = {16'd0, rdata_q[15:0]};
        default: r_val = 32'd0;
      endcase
      r_idx     = pend_dest;
      r_rw      = (pend_dest != 5'd0);
      r_cur     = pc - 32'd4;
      mode_next = M_RUN;
    end else if (func_q == FN_RESUME && mode == M_ECALL) begin
      if (wa0_q) begin
        wr    = 1'b1;
        r_rw  = 1'b1;
        r_idx = REG_A0;
        r_val = rdata_q;
      end
      r_cur = pc - 32'd4;
      if (keep_q) begin
        mode_next = M_RUN;
      end else begin
        mode_next = M_HALT;
        r_status  = ST_HALTED;
      end
    end else begin
      r_status = {1'b0, mode};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 32'd0;
      mode      <= M_RUN;
      pend_dest <= 5'd0;
      pend_kind <= 3'd0;
    end else if (start_pc_write) begin
      pc        <= start_pc;
      mode      <= M_RUN;
      pend_dest <= 5'd0;
      pend_kind <= 3'd0;
    end else if (cmd.commit) begin
      pc        <= pc_next;
      mode      <= mode_next;
      pend_dest <= pd_next;
      pend_kind <= pk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= r_status;
      cur_pc      <= r_cur;
      next_pc     <= r_next;
      is_branch   <= r_br;
      taken       <= r_tk;
      reg_write   <= r_rw;
      reg_index   <= r_idx;
      write_value <= r_val;
      access_addr <= r_addr;
      mem_data    <= r_data;
      mem_bytes   <= r_bytes;
      call_code   <= r_call;
    end
  end

endmodule

/* rtl/rv32_ctrl.sv */
// ----------------------------------------------------------------------------
// RV32IM executor controller
// Sequences register read, multiply, divide iterations and result commit.
// ----------------------------------------------------------------------------
module rv32_ctrl import rv32_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ: begin
        if (sts.is_mul) state_next = S_MUL;
        else if (sts.is_div) state_next = S_DIV;
        else state_next = S_COMMIT;
      end
      S_MUL:    state_next = S_COMMIT;
      S_DIV:    if (sts.div_last) state_next = S_COMMIT;
      S_COMMIT: if (!sts.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_READ:   cmd.div_start = sts.is_div;
      S_MUL:    cmd.mul_en = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_COMMIT: cmd.commit = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

/* rtl/rv32_checker.sv */
// ----------------------------------------------------------------------------
// RV32IM executor port checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "rv32im_instruction_executor_assert.svh"

module rv32_checker import rv32_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] cur_pc,
  input logic [31:0] next_pc,
  input logic        is_branch,
  input logic        taken,
  input logic        reg_write,
  input logic [4:0]  reg_index
);

  `RV_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(cur_pc))
  `RV_ASSERT_NOW(a_illegal_pc, out_valid && status == ST_ILLEGAL, next_pc == cur_pc)
  `RV_ASSERT_NOW(a_no_x0, out_valid && reg_write, reg_index != 5'd0)
  `RV_ASSERT_NOW(a_taken_br, out_valid && taken, is_branch)

endmodule

bind rv32im_instruction_executor rv32_checker u_chk (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// RV32IM executor testbench
// Drives execute, load-data and resume beats through the valid/stall
// handshake, predicts each result from a shadow register file and pc, and
// compares every result beat field by field. Covers every opcode, the M
// extension corner cases, split loads, ecalls, restarts and illegal opcodes.
// ----------------------------------------------------------------------------
module testbench;
  import rv32_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] cur_pc;
    logic [31:0] next_pc;
    logic        is_branch;
    logic        taken;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [31:0] access_addr;
    logic [31:0] mem_data;
    logic [2:0]  mem_bytes;
    logic [31:0] call_code;
  } exec_result_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [31:0] instruction = '0;
  logic [31:0] return_data = '0;
  logic        write_a0 = 0;
  logic        keep_running = 0;
  logic        start_pc_write = 0;
  logic [31:0] start_pc = '0;
  logic        out_valid;
  logic        out_stall = 0;
  exec_result_t got;

  rv32im_instruction_executor dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .instruction(instruction), .return_data(return_data), .write_a0(write_a0),
    .keep_running(keep_running), .start_pc_write(start_pc_write), .start_pc(start_pc),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(got.status), .cur_pc(got.cur_pc), .next_pc(got.next_pc),
    .is_branch(got.is_branch), .taken(got.taken), .reg_write(got.reg_write),
    .reg_index(got.reg_index), .write_value(got.write_value),
    .access_addr(got.access_addr),
    .mem_data(got.mem_data), .mem_bytes(got.mem_bytes), .call_code(got.call_code)
  );

  always #4 clk = ~clk;

  logic [31:0]  shadow_regs [32];
  logic [31:0]  shadow_pc;
  mode_t        shadow_mode;
  logic [4:0]   load_dest;
  logic [2:0]   load_kind;
  exec_result_t expected_results [$];
  int           errors = 0;
  int           cycles = 0;
  int           beats_sent = 0;
  int           beats_checked = 0;
  int           out_wait = 0;
  bit           idle_gaps = 1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] g, input logic [31:0] e);
    errors++;
    $display("mismatch %s: got %h expected %h (beat %0d)", what, g, e, beats_checked);
  endtask

  function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
    logic [31:0] m;
    m = (bits >= 32) ? 32'hFFFFFFFF : ((32'd1 << bits) - 1);
    v &= m;
    return (v ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1));
  endfunction

  function automatic exec_result_t execute_beat(input logic [1:0] fn, input logic [31:0] ins,
                                                input logic [31:0] rdata, input logic wa0,
                                                input logic keep);
    exec_result_t r;
    logic [6:0] opc, f7;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [31:0] a, b, immi, imms, immb, immj, npc, val, q;
    logic signed [63:0] pr;
    logic wr, t;
    r = '0;
    r.cur_pc = shadow_pc;
    r.next_pc = shadow_pc;
    if (fn == FN_EXEC && shadow_mode == M_RUN) begin
      opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
      rs1 = ins[19:15]; rs2 = ins[24:20]; f7 = ins[31:25];
      a = shadow_regs[rs1]; b = shadow_regs[rs2];
      immi = {{20{ins[31]}}, ins[31:20]};
      imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      npc = shadow_pc + 4; wr = 0; val = 0; t = 0;
      case (opc)
        OP_LUI: begin wr = 1; val = {ins[31:12], 12'b0}; end
        OP_AUIPC: begin wr = 1; val = shadow_pc + {ins[31:12], 12'b0}; end
        OP_JAL: begin wr = 1; val = shadow_pc + 4; npc = shadow_pc + immj; end
        OP_JALR: if (f3 == 0) begin
          wr = 1; val = shadow_pc + 4; npc = (a + immi) & ~32'd1;
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: t = a == b;
            3'd1: t = a != b;
            3'd4: t = $signed(a) < $signed(b);
            3'd5: t = !($signed(a) < $signed(b));
            3'd6: t = a < b;
            3'd7: t = a >= b;
            default: t = 0;
          endcase
          r.is_branch = 1; r.taken = t;
          if (t) npc = shadow_pc + immb;
        end
        OP_IMM: begin
          wr = 1;
          case (f3)
            3'd0: val = a + immi;
            3'd2: val = ($signed(a) < $signed(immi)) ? 1 : 0;
            3'd3: val = (a < immi) ? 1 : 0;
            3'd4: val = a ^ immi;
            3'd6: val = a | immi;
            3'd7: val = a & immi;
            3'd1: if (f7 == F7_BASE) val = a << rs2; else wr = 0;
            default:
              if (f7 == F7_BASE) val = a >> rs2;
              else if (f7 == F7_ALT) val = $signed(a) >>> rs2;
              else wr = 0;
          endcase
        end
        OP_REG: begin
          wr = 1;
          if (f7 == F7_BASE) begin
            case (f3)
              3'd0: val = a + b;
              3'd1: val = a << b[4:0];
              3'd2: val = ($signed(a) < $signed(b)) ? 1 : 0;
              3'd3: val = (a < b) ? 1 : 0;
              3'd4: val = a ^ b;
              3'd5: val = a >> b[4:0];
              3'd6: val = a | b;
              default: val = a & b;
            endcase
          end else if (f7 == F7_ALT) begin
            if (f3 == 0) val = a - b;
            else if (f3 == 5) val = $signed(a) >>> b[4:0];
            else wr = 0;
          end else if (f7 == F7_MULDIV) begin
            case (f3)
              3'd0: val = a * b;
              3'd1: begin pr = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                val = pr[63:32]; end
              3'd2: begin pr = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
                val = pr[63:32]; end
              3'd3: val = ({32'd0, a} * {32'd0, b}) >> 32;
              3'd4: begin
                if (b == 0) val = '1;
                else if (a == 32'h80000000 && b == '1) val = a;
                else begin
                  q = (a[31] ? -a : a) / (b[31] ? -b : b);
                  val = (a[31] ^ b[31]) ? -q : q;
                end
              end
              3'd5: val = (b == 0) ? '1 : a / b;
              3'd6: begin
                if (b == 0) val = a;
                else if (a == 32'h80000000 && b == '1) val = 0;
                else begin
                  q = (a[31] ? -a : a) % (b[31] ? -b : b);
                  val = a[31] ? -q : q;
                end
              end
              default: val = (b == 0) ? a : a % b;
            endcase
          end else wr = 0;
        end
        OP_STORE: if (f3 <= 2) begin
          r.access_addr = a + imms;
          r.mem_bytes = 3'd1 << f3;
          r.mem_data = (f3 == 0) ? (b & 32'hFF) : (f3 == 1) ? (b & 32'hFFFF) : b;
        end
        OP_LOAD: begin
          r.status = ST_LOAD;
          r.access_addr = a + immi;
          r.mem_bytes = (f3 == 3 || f3 >= 6) ? 3'd0 : (3'd1 << f3[1:0]);
          r.reg_index = rd;
          load_dest = rd; load_kind = f3;
          shadow_mode = M_LOAD;
        end
        OP_SYSTEM: if (f3 == 0 && ins[31:20] == 0) begin
          r.status = ST_ECALL;
          r.write_value = shadow_regs[REG_A0];
          r.call_code = shadow_regs[REG_A7];
          shadow_mode = M_ECALL;
        end
        default: begin
          r.status = ST_ILLEGAL; npc = shadow_pc; shadow_mode = M_HALT;
        end
      endcase
      if (wr) begin
        if (rd != 0) shadow_regs[rd] = val;
        r.reg_write = rd != 0; r.reg_index = rd; r.write_value = val;
      end
      r.next_pc = npc;
      shadow_pc = npc;
    end else if (fn == FN_LOAD && shadow_mode == M_LOAD) begin
      case (load_kind)
        3'd0: val = sx(rdata, 8);
        3'd1: val = sx(rdata, 16);
        3'd2: val = rdata;
        3'd4: val = rdata & 32'hFF;
        3'd5: val = rdata & 32'hFFFF;
        default: val = 0;
      endcase
      if (load_dest != 0) shadow_regs[load_dest] = val;
      r.cur_pc = shadow_pc - 4;
      r.reg_write = load_dest != 0; r.reg_index = load_dest; r.write_value = val;
      shadow_mode = M_RUN;
    end else if (fn == FN_RESUME && shadow_mode == M_ECALL) begin
      if (wa0) begin
        shadow_regs[REG_A0] = rdata;
        r.reg_write = 1; r.reg_index = REG_A0; r.write_value = rdata;
      end
      r.cur_pc = shadow_pc - 4;
      if (keep) shadow_mode = M_RUN;
      else begin shadow_mode = M_HALT; r.status = ST_HALTED; end
    end else begin
      r.status = {1'b0, shadow_mode};
    end
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] fn, input logic [31:0] ins,
                           input logic [31:0] rdata, input logic wa0, input logic keep);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    func <= fn; instruction <= ins; return_data <= rdata;
    write_a0 <= wa0; keep_running <= keep; in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(execute_beat(fn, ins, rdata, wa0, keep));
    beats_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= (out_wait > 0);
    if (out_wait > 0) out_wait--;
  end

  always @(posedge clk) begin
    exec_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        e = expected_results.pop_front();
        if (got.status !== e.status) report("status", got.status, e.status);
        if (got.cur_pc !== e.cur_pc) report("cur_pc", got.cur_pc, e.cur_pc);
        if (got.next_pc !== e.next_pc) report("next_pc", got.next_pc, e.next_pc);
        if (got.is_branch !== e.is_branch) report("is_branch", got.is_branch, e.is_branch);
        if (got.taken !== e.taken) report("taken", got.taken, e.taken);
        if (got.reg_write !== e.reg_write) report("reg_write", got.reg_write, e.reg_write);
        if (got.reg_index !== e.reg_index) report("reg_index", got.reg_index, e.reg_index);
        if (got.write_value !== e.write_value)
          report("write_value", got.write_value, e.write_value);
        if (got.access_addr !== e.access_addr)
          report("access_addr", got.access_addr, e.access_addr);
        if (got.mem_data !== e.mem_data) report("mem_data", got.mem_data, e.mem_data);
        if (got.mem_bytes !== e.mem_bytes) report("mem_bytes", got.mem_bytes, e.mem_bytes);
        if (got.call_code !== e.call_code) report("call_code", got.call_code, e.call_code);
      end
      beats_checked++;
      out_wait = idle_gaps ? $urandom_range(0, 17) : 0;
    end
  end

  task automatic drain;
    in_valid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic restart(input logic [31:0] pc);
    drain();
    start_pc <= pc; start_pc_write <= 1;
    @(negedge clk);
    start_pc_write <= 0;
    shadow_pc = pc; shadow_mode = M_RUN; load_dest = 0; load_kind = 0;
  endtask

  function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return '1;
      2: return 0;
      3: return $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_reg(input logic [4:0] rd, input logic [31:0] v);
    send_beat(FN_EXEC, {v[31:12] + v[11], rd, OP_LUI}, 0, 0, 0);
    send_beat(FN_EXEC, {v[11:0], rd, 3'd0, rd, OP_IMM}, 0, 0, 0);
  endtask

  task automatic test_directed;
    load_reg(5'd1, 32'h80000000);
    load_reg(5'd2, 32'hFFFFFFFF);
    load_reg(5'd3, 32'd0);
    send_beat(FN_EXEC, r_type(F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd4, OP_REG), 0, 0, 0);
    send_beat(FN_EXEC, r_type(F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd5, OP_REG), 0, 0, 0);
    send_beat(FN_EXEC, r_type(F7_MULDIV, 5'd3, 5'd1, 3'd5, 5'd6, OP_REG), 0, 0, 0);
    send_beat(FN_EXEC, r_type(F7_MULDIV, 5'd3, 5'd1, 3'd7, 5'd7, OP_REG), 0, 0, 0);
    send_beat(FN_EXEC, r_type(F7_MULDIV, 5'd2, 5'd1, 3'd1, 5'd8, OP_REG), 0, 0, 0);
    send_beat(FN_EXEC, {12'hFFF, 5'd1, 3'd3, 5'd9, OP_LOAD}, 0, 0, 0);
    send_beat(FN_EXEC, 0, 0, 0, 0);
    send_beat(FN_LOAD, 0, 32'hDEADBEEF, 0, 0);
    send_beat(FN_EXEC, {12'd5, 5'd2, 3'd0, 5'd0, OP_LOAD}, 0, 0, 0);
    send_beat(FN_LOAD, 0, 32'h80, 0, 0);
    send_beat(FN_EXEC, {7'h7F, 5'd2, 5'd1, 3'd2, 5'd31, OP_STORE}, 0, 0, 0);
    send_beat(FN_EXEC, {7'h01, 5'd2, 5'd1, 3'd2, 5'd4, OP_BRANCH}, 0, 0, 0);
    send_beat(FN_EXEC, {12'd0, 5'd0, 3'd0, 5'd0, OP_SYSTEM}, 0, 0, 0);
    send_beat(FN_LOAD, 0, 1, 0, 0);
    send_beat(FN_RESUME, 0, 32'h12345678, 1, 1);
    send_beat(FN_EXEC, {12'd0, 5'd0, 3'd0, 5'd0, OP_SYSTEM}, 0, 0, 0);
    send_beat(FN_RESUME, 0, 0, 0, 0);
    send_beat(FN_EXEC, 32'h13, 0, 0, 0);
    send_beat(2'd3, 0, 0, 0, 0);
    restart(32'hFFFFFFFC);
    send_beat(FN_EXEC, 32'h0000007F, 0, 0, 0);
    send_beat(FN_EXEC, 32'h13, 0, 0, 0);
    restart('1);
  endtask

  task automatic test_random(input int count);
    logic [31:0] ins;
    logic [6:0] ops [10];
    ops = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_IMM, OP_REG,
            OP_STORE, OP_LOAD, OP_SYSTEM};
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) restart($urandom);
      if (n % 60 == 30) idle_gaps = !idle_gaps;
      if ($urandom_range(0, 9) == 0) load_reg(5'($urandom), rand_word());
      if (shadow_mode == M_LOAD && $urandom_range(0, 9) != 0) begin
        send_beat(FN_LOAD, $urandom, rand_word(), 1'($urandom), 1'($urandom));
      end else if (shadow_mode == M_ECALL && $urandom_range(0, 9) != 0) begin
        send_beat(FN_RESUME, $urandom, rand_word(), 1'($urandom),
                  $urandom_range(0, 7) != 0);
      end else if (shadow_mode == M_HALT) begin
        if ($urandom_range(0, 1))
          send_beat(2'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom));
        else restart($urandom);
      end else begin
        ins = $urandom;
        case ($urandom_range(0, 19))
          0: ins[6:0] = 7'($urandom);
          1: ins[6:0] = OP_SYSTEM;
          2: begin ins[6:0] = OP_SYSTEM; ins[31:12] = 0; end
          3, 4, 5: begin ins[6:0] = OP_REG; ins[31:25] = F7_MULDIV; end
          6: begin ins[6:0] = OP_REG; ins[31:25] = ($urandom_range(0, 1)) ? F7_ALT : F7_BASE; end
          7: begin ins[6:0] = OP_IMM; ins[31:25] = ($urandom_range(0, 1)) ? F7_ALT : F7_BASE; end
          default: ins[6:0] = ops[$urandom_range(0, 9)];
        endcase
        send_beat($urandom_range(0, 19) == 0 ? 2'($urandom) : FN_EXEC, ins, $urandom,
                  1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) shadow_regs[i] = 0;
    shadow_pc = 0; shadow_mode = M_RUN; load_dest = 0; load_kind = 0;
    repeat (5) @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(450);
    drain();
    $display("sent %0d beats, checked %0d results over %0d cycles",
             beats_sent, beats_checked, cycles);
    $display("covered all opcodes, M-extension corners, loads, ecalls and restarts");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
